/* src/srle_pkg.sv */
`default_nettype none

package srle_pkg;

  // Most result bytes that one input byte can cause: a three-byte flush
  // followed by the end mark and the final byte itself.
  localparam int unsigned MAX_RESULTS = 5;
  localparam int unsigned COUNT_W     = $clog2(MAX_RESULTS + 1);
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0]  END_MARK    = 8'd31;
  localparam logic [7:0]  RUN_MAX     = 8'd255;
  localparam logic [4:0]  LIT_RESET   = 5'd1;
  localparam logic [5:0]  LIT_FULL    = 6'd31;
  localparam logic [5:0]  LIT_HIGH    = 6'd30;
  localparam logic [16:0] HEADER_LEN  = 17'd8;

  // One queue entry: every result byte caused by one accepted input byte.
  typedef struct packed {
    logic [COUNT_W-1:0]               count;
    logic                             ovf;
    logic [MAX_RESULTS-1:0]           ctl;
    logic [MAX_RESULTS-1:0][7:0]      bytes;
  } srle_entry_t;

endpackage

`default_nettype wire

/* src/srle_front.sv */
`default_nettype none

module srle_front #(
  parameter int unsigned CONTROL_LIMIT = 65535
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          in_byte,
  input  wire logic                final_byte,
  input  wire logic                q_full,
  output logic                     push,
  output srle_pkg::srle_entry_t    push_entry
);

  logic [7:0]  prev_byte;
  logic [7:0]  run_count;
  logic [4:0]  literal_count;
  logic [16:0] control_length;
  logic        aborted;

  logic                         accept;
  logic                         do_flush;
  logic                         ovf;
  logic                         emit;
  logic [srle_pkg::COUNT_W-1:0] n;
  logic [1:0]                   nctl;
  logic [5:0]                   lc6;
  logic [7:0]                   run_next;
  logic [16:0]                  control_length_next;
  srle_pkg::srle_entry_t        ent;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    ent      = '0;
    n        = '0;
    nctl     = '0;
    lc6      = {1'b0, literal_count};
    do_flush = (run_count != 8'd0) &&
               ((prev_byte != in_byte) || (run_count == srle_pkg::RUN_MAX) ||
                final_byte || (literal_count == 5'd0));
    if (do_flush) begin
      if (run_count == 8'd1) begin
        ent.bytes[0] = prev_byte;
        n   = 3'd1;
        lc6 = lc6 + 6'd1;
        if (lc6 == srle_pkg::LIT_FULL) begin
          ent.bytes[1] = srle_pkg::END_MARK;
          ent.ctl[1]   = 1'b1;
          n    = 3'd2;
          nctl = 2'd1;
          lc6  = 6'd0;
        end
      end else if (run_count == 8'd2) begin
        ent.bytes[0] = prev_byte;
        ent.bytes[1] = prev_byte;
        n   = 3'd2;
        lc6 = lc6 + 6'd2;
        if (lc6 > srle_pkg::LIT_HIGH) begin
          ent.bytes[2] = srle_pkg::END_MARK;
          ent.ctl[2]   = 1'b1;
          n    = 3'd3;
          nctl = 2'd1;
          lc6  = lc6 - srle_pkg::LIT_FULL;
        end
      end else if (run_count < 8'd8) begin
        // short run: literal count in the low five bits, run above
        ent.bytes[0] = {run_count[2:0], literal_count};
        ent.ctl[0]   = 1'b1;
        ent.bytes[1] = prev_byte;
        n    = 3'd2;
        nctl = 2'd1;
        lc6  = {1'b0, srle_pkg::LIT_RESET};
      end else begin
        ent.bytes[0] = {3'b000, literal_count};
        ent.ctl[0]   = 1'b1;
        ent.bytes[1] = run_count;
        ent.ctl[1]   = 1'b1;
        ent.bytes[2] = prev_byte;
        n    = 3'd3;
        nctl = 2'd2;
        lc6  = {1'b0, srle_pkg::LIT_RESET};
      end
    end
    run_next = do_flush ? 8'd1 : run_count + 8'd1;
    if (final_byte) begin
      ent.bytes[n]        = srle_pkg::END_MARK;
      ent.ctl[n]          = 1'b1;
      ent.bytes[n + 3'd1] = in_byte;
      n    = n + 3'd2;
      nctl = nctl + 2'd1;
    end
    control_length_next = control_length + {15'd0, nctl};
    ovf       = control_length_next > 17'(CONTROL_LIMIT);
    ent.count = n;
    if (aborted || ovf) begin
      ent       = '0;
      ent.count = 3'd1;
      ent.ovf   = 1'b1;
    end
    emit = aborted || ovf || (n != 3'd0);
  end

  assign push       = accept && emit;
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_byte      <= '0;
      run_count      <= '0;
      literal_count  <= srle_pkg::LIT_RESET;
      control_length <= srle_pkg::HEADER_LEN;
      aborted        <= 1'b0;
    end else if (accept && !aborted) begin
      if (ovf) begin
        aborted <= 1'b1;
      end
      if (final_byte) begin
        prev_byte      <= '0;
        run_count      <= '0;
        literal_count  <= srle_pkg::LIT_RESET;
        control_length <= srle_pkg::HEADER_LEN;
      end else begin
        prev_byte      <= in_byte;
        run_count      <= run_next;
        literal_count  <= lc6[4:0];
        control_length <= control_length_next;
      end
    end
  end

  a_abort_sticky: assert property (@(posedge clk) disable iff (rst)
    aborted |=> aborted) else $error("abort flag dropped without reset");

  a_entry_size: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_entry.count != 3'd0) &&
             (push_entry.count <= 3'(srle_pkg::MAX_RESULTS)))
    else $error("queue entry with bad byte count");

endmodule

`default_nettype wire

/* src/srle_queue.sv */
`default_nettype none

module srle_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire srle_pkg::srle_entry_t push_entry,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       nonempty,
  output srle_pkg::srle_entry_t      head
);

  localparam int unsigned PTR_W = $clog2(srle_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(srle_pkg::QUEUE_DEPTH + 1);

  srle_pkg::srle_entry_t slots [srle_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = (fill == CNT_W'(srle_pkg::QUEUE_DEPTH));
  assign nonempty = (fill != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("write into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty) else $error("read from empty queue");

endmodule

`default_nettype wire

/* src/srle_back.sv */
`default_nettype none

module srle_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  nonempty,
  input  wire srle_pkg::srle_entry_t head,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_byte,
  output logic                       to_control,
  output logic                       last_of_run,
  output logic                       overflow
);

  logic [srle_pkg::COUNT_W-1:0] idx;
  logic                         load;
  logic                         is_last;

  assign load    = nonempty && (!out_valid || !out_stall);
  assign is_last = (idx == head.count - 3'd1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? '0 : idx + 3'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= head.bytes[idx];
      to_control  <= head.ctl[idx];
      last_of_run <= is_last;
      overflow    <= head.ovf;
    end
  end

  a_idx_in_entry: assert property (@(posedge clk) disable iff (rst)
    nonempty |-> (idx < head.count)) else $error("byte index past entry");

  a_ovf_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> last_of_run)
    else $error("overflow result not closing its item");

endmodule

`default_nettype wire

/* src/split_stream_rle_encoder.sv */
`default_nettype none

// channel   signals                                         direction
// input     in_valid, in_stall, in_byte, final_byte         into block
// output    out_valid, out_stall, out_byte, to_control,     out of block
//           last_of_run, overflow
//
// An input byte is classified and the run state updated in the cycle of its
// transfer. An input byte causing k results gives k result bytes, one per
// cycle while out_stall is low, through the output register; a four-entry
// queue between the classifier and the serialiser absorbs such bursts.
// in_stall rises only when the queue is full, so output stalls reach the
// input after the queue fills.
// Synchronous reset restarts the stream and clears the sticky overflow.
module split_stream_rle_encoder #(
  parameter int unsigned CONTROL_LIMIT = 65535
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       final_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            to_control,
  output logic            last_of_run,
  output logic            overflow
);

  // Front to queue: one entry per input transfer that yields results.
  logic                  push;
  srle_pkg::srle_entry_t push_entry;
  logic                  q_full;

  // Queue to back: head entry, drop it once its last byte is loaded.
  logic                  pop;
  logic                  nonempty;
  srle_pkg::srle_entry_t head;

  // Classify each byte: flush runs, close literal groups, add the end mark
  // and track the control stream length against the limit.
  srle_front #(
    .CONTROL_LIMIT(CONTROL_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Hold pending entries so that front and back stall independently.
  srle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .nonempty   (nonempty),
    .head       (head)
  );

  // Serialise each entry, one result byte per output transfer.
  srle_back u_back (
    .clk         (clk),
    .rst         (rst),
    .nonempty    (nonempty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .to_control  (to_control),
    .last_of_run (last_of_run),
    .overflow    (overflow)
  );

endmodule

`default_nettype wire
